/* design/hafr_pkg.sv */
// shared types, codes and helpers for the hex-ascii frame receiver
`default_nettype none

package hafr_pkg;

  // frame phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_INFO,
    PH_CHECK,
    PH_END
  } phase_t;

  // end report status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_START_LIM = 3'd1;
  localparam logic [2:0] STAT_NO_RESP   = 3'd2;
  localparam logic [2:0] STAT_TRUNC     = 3'd3;
  localparam logic [2:0] STAT_LEN_CHK   = 3'd4;
  localparam logic [2:0] STAT_CHKSUM    = 3'd5;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] START_MARK = 8'h7e;
  localparam logic [3:0] MAX_BAD_START_RST = 4'd10;
  localparam logic [3:0] HEADER_CHARS = 4'd8;
  localparam logic [12:0] LEN_DONE = 13'd12;
  localparam logic [12:0] CHK_CHARS = 13'd4;

  // input word
  typedef struct packed {
    logic [7:0] rx_char;
    logic       timeout_tick;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [7:0]  frame_ver;
    logic [7:0]  frame_adr;
    logic [7:0]  frame_cid1;
    logic [7:0]  frame_cid2;
    logic [11:0] info_chars;
    logic        last;
  } out_word_t;

  // receiver state carried between words
  typedef struct packed {
    phase_t      phase;
    logic [12:0] char_count;
    logic [15:0] char_sum;
    logic [3:0]  high_nibble;
    logic [7:0]  header_ver;
    logic [7:0]  header_adr;
    logic [7:0]  header_cid1;
    logic [7:0]  header_cid2;
    logic [15:0] length_word;
    logic [15:0] rx_checksum;
    logic [3:0]  bad_start_count;
  } state_t;

  localparam state_t STATE_RST = '{
    phase:           PH_HUNT,
    char_count:      13'd0,
    char_sum:        16'd0,
    high_nibble:     4'd0,
    header_ver:      8'd0,
    header_adr:      8'd0,
    header_cid1:     8'd0,
    header_cid2:     8'd0,
    length_word:     16'd0,
    rx_checksum:     16'd0,
    bad_start_count: 4'd0
  };

  // hex character to nibble, anything else decodes as zero
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/hex_ascii_frame_receiver.sv */
// top level of the hex-ascii frame receiver
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall   in_word  (rx_char, timeout_tick)
//   out      output     out_valid/out_stall out_word (data byte or end report)
//   cfg      input      cfg_wr_en           cfg_wr_data (max_bad_start)
//
// one word per cycle while out_stall does not hold a full result register; a word's
// result passes the input register, then the per-character logic, into the result register.
// a word producing no result still takes one pass through the input register.
// rst_n is synchronous; it clears the frame state and sets max_bad_start to 10.
// out_stall holds the result register; in_stall rises only when a word waits
// in the input register and the result register cannot take a new result.
`default_nettype none

module hex_ascii_frame_receiver import hafr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_word,
  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data
);

  logic       in_valid_r;
  in_word_t   in_word_r;
  state_t     state_r;
  state_t     state_nxt;
  logic [3:0] max_bad_start_r;
  logic       out_valid_r;
  out_word_t  out_word_r;
  logic       res_valid;
  out_word_t  res;
  logic       adv;

  // a buffered word moves on when the result register is free or draining
  assign adv      = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & ~adv;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // per-character logic
  hafr_step u_step (
    .cur           (state_r),
    .word          (in_word_r),
    .max_bad_start (max_bad_start_r),
    .state_nxt     (state_nxt),
    .res_valid     (res_valid),
    .res           (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_word;
    end
  end

  // receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bad_start_r <= MAX_BAD_START_RST;
    end else if (cfg_wr_en) begin
      max_bad_start_r <= cfg_wr_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_word_r <= res;
    end
  end

endmodule

`default_nettype wire

/* design/hafr_step.sv */
// per-character next state and result logic of the frame receiver
`default_nettype none

module hafr_step import hafr_pkg::*; (
  input  state_t     cur,
  input  in_word_t   word,
  input  logic [3:0] max_bad_start,
  output state_t     state_nxt,
  output logic       res_valid,
  output out_word_t  res
);

  logic [3:0]  nib;
  logic [3:0]  bad_inc;
  logic [12:0] cnt_inc;
  logic [15:0] sum_add;
  logic [15:0] lw_shift;
  logic [5:0]  len_sum;
  logic [3:0]  len_chk;
  logic [7:0]  pair_byte;

  // shared arithmetic
  always_comb begin
    nib       = hex_val(word.rx_char);
    bad_inc   = cur.bad_start_count + 4'd1;
    cnt_inc   = cur.char_count + 13'd1;
    sum_add   = cur.char_sum + {8'd0, word.rx_char};
    lw_shift  = {cur.length_word[11:0], nib};
    len_sum   = {2'b00, lw_shift[11:8]} + {2'b00, lw_shift[7:4]} + {2'b00, lw_shift[3:0]};
    len_chk   = 4'(6'd0 - len_sum);
    pair_byte = {cur.high_nibble, nib};
  end

  // phase update and result
  always_comb begin
    state_nxt = cur;
    res_valid = 1'b0;
    res.kind       = KIND_END;
    res.data_byte  = 8'd0;
    res.status     = STAT_OK;
    res.frame_ver  = cur.header_ver;
    res.frame_adr  = cur.header_adr;
    res.frame_cid1 = cur.header_cid1;
    res.frame_cid2 = cur.header_cid2;
    res.info_chars = (cur.phase == PH_HEADER) ? 12'd0 : cur.length_word[11:0];
    res.last       = 1'b1;

    if (cur.phase == PH_HUNT) begin
      res.frame_ver  = 8'd0;
      res.frame_adr  = 8'd0;
      res.frame_cid1 = 8'd0;
      res.frame_cid2 = 8'd0;
      res.info_chars = 12'd0;
      if (word.timeout_tick) begin
        // no response
        state_nxt  = STATE_RST;
        res_valid  = 1'b1;
        res.status = STAT_NO_RESP;
      end else if (word.rx_char == START_MARK) begin
        state_nxt       = STATE_RST;
        state_nxt.phase = PH_HEADER;
      end else if (bad_inc >= max_bad_start || bad_inc == 4'd0) begin
        state_nxt.bad_start_count = 4'd0;
        res_valid  = 1'b1;
        res.status = STAT_START_LIM;
      end else begin
        state_nxt.bad_start_count = bad_inc;
      end
    end else if (word.timeout_tick) begin
      // truncated frame
      state_nxt = STATE_RST;
      state_nxt.bad_start_count = cur.bad_start_count;
      res_valid  = 1'b1;
      res.status = STAT_TRUNC;
    end else begin
      case (cur.phase)
        PH_HEADER: begin
          state_nxt.char_sum   = sum_add;
          state_nxt.char_count = cnt_inc;
          if (cur.char_count < {9'd0, HEADER_CHARS}) begin
            if (!cur.char_count[0]) begin
              state_nxt.high_nibble = nib;
            end else begin
              case (cur.char_count[2:1])
                2'd0:    state_nxt.header_ver  = pair_byte;
                2'd1:    state_nxt.header_adr  = pair_byte;
                2'd2:    state_nxt.header_cid1 = pair_byte;
                default: state_nxt.header_cid2 = pair_byte;
              endcase
            end
          end else begin
            state_nxt.length_word = lw_shift;
            if (cnt_inc == LEN_DONE) begin
              if (lw_shift[15:12] != len_chk) begin
                // bad length checksum ends the frame
                state_nxt = STATE_RST;
                state_nxt.bad_start_count = cur.bad_start_count;
                res_valid      = 1'b1;
                res.status     = STAT_LEN_CHK;
                res.info_chars = lw_shift[11:0];
              end else begin
                state_nxt.char_count = 13'd0;
                state_nxt.phase = (lw_shift[11:0] == 12'd0) ? PH_CHECK : PH_INFO;
              end
            end
          end
        end
        PH_INFO: begin
          // pair characters into data bytes
          state_nxt.char_sum   = sum_add;
          state_nxt.char_count = cnt_inc;
          if (!cur.char_count[0]) begin
            state_nxt.high_nibble = nib;
          end else begin
            res_valid     = 1'b1;
            res.kind      = KIND_DATA;
            res.data_byte = pair_byte;
            res.last      = 1'b0;
          end
          if (cnt_inc >= {1'b0, cur.length_word[11:0]}) begin
            state_nxt.phase      = PH_CHECK;
            state_nxt.char_count = 13'd0;
          end
        end
        PH_CHECK: begin
          state_nxt.rx_checksum = {cur.rx_checksum[11:0], nib};
          state_nxt.char_count  = cnt_inc;
          if (cnt_inc >= CHK_CHARS) begin
            state_nxt.phase      = PH_END;
            state_nxt.char_count = 13'd0;
          end
        end
        default: begin
          // end character, taken unchecked
          state_nxt = STATE_RST;
          state_nxt.bad_start_count = cur.bad_start_count;
          res_valid  = 1'b1;
          res.status = (cur.rx_checksum == 16'(16'd0 - cur.char_sum)) ? STAT_OK : STAT_CHKSUM;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
